// ===== hw/rtl/lru_pkg.sv =====
// Shared widths, chain records and controller states for the LRU page replacement block.
package lru_pkg;

   // Fixed field widths of the request, response and CSR
   localparam int PAGE_NUMBER_W = 16;
   localparam int SLOT_OUT_W    = 3;
   localparam int TOTAL_W       = 32;
   localparam int CSR_W         = 4;

   // Frame index and rank width covering the largest supported frame count (64)
   localparam int IDX_W   = 6;
   // Active frame count width, holds the frame count itself
   localparam int COUNT_W = 7;

   localparam logic [CSR_W-1:0] CSR_RESET = 4'd8;

   // Search record handed from cell to cell
   typedef struct packed {
      logic             live;
      logic             hit_found;
      logic [IDX_W-1:0] hit_slot;
      logic [IDX_W-1:0] hit_rank;
      logic             empty_found;
      logic [IDX_W-1:0] empty_slot;
      logic [IDX_W-1:0] victim_slot;
      logic [IDX_W-1:0] victim_rank;
   } scan_type;

   localparam scan_type SCAN_IDLE = '0;

   // Update broadcast from the controller to every cell
   typedef struct packed {
      logic             apply;
      logic             write_page;
      logic             limit_en;
      logic [IDX_W-1:0] target;
      logic [IDX_W-1:0] limit;
   } update_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

endpackage

// ===== hw/rtl/lru_req_if.sv =====
// Request channel: one page reference per request.
interface lru_req_if;
   logic                             valid;
   logic                             ready;
   logic [lru_pkg::PAGE_NUMBER_W-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink (input valid, input page_number, output ready);
endinterface

// ===== hw/rtl/lru_rsp_if.sv =====
// Response channel: hit or fault, frame used and running totals.
interface lru_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [lru_pkg::SLOT_OUT_W-1:0] frame_slot;
   logic [lru_pkg::TOTAL_W-1:0]    hit_total;
   logic [lru_pkg::TOTAL_W-1:0]    fault_total;

   modport source (output valid, output hit, output frame_slot, output hit_total,
                   output fault_total, input ready);
   modport sink (input valid, input hit, input frame_slot, input hit_total,
                 input fault_total, output ready);
endinterface

// ===== hw/rtl/lru_cell.sv =====
// One frame cell: holds page, valid and rank, folds itself into the passing search record.
module lru_cell #(
   parameter int INDEX       = 0,
   parameter int FRAME_COUNT = 8,
   parameter int PAGE_W      = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lru_pkg::scan_type           scan_in,
   output lru_pkg::scan_type           scan_out,
   input  lru_pkg::update_type         update,
   input  logic [PAGE_W-1:0]           page,
   input  logic [lru_pkg::COUNT_W-1:0] active_count
);

   localparam int RANK_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam logic [lru_pkg::IDX_W-1:0] MY_SLOT   = lru_pkg::IDX_W'(INDEX);
   localparam logic [RANK_W-1:0]         RANK_CEIL = RANK_W'(FRAME_COUNT - 1);

   logic [PAGE_W-1:0]         page_ff;
   logic                      valid_ff;
   logic [RANK_W-1:0]         rank_ff;
   lru_pkg::scan_type         scan_ff;
   lru_pkg::scan_type         scan_in_next;
   logic                      active;
   logic [lru_pkg::IDX_W-1:0] rank_wide;
   logic                      is_target;
   logic                      age;

   assign active    = lru_pkg::COUNT_W'(INDEX) < active_count;
   assign rank_wide = lru_pkg::IDX_W'(rank_ff);
   assign is_target = update.target == MY_SLOT;
   assign scan_out  = scan_ff;

   // Fold this frame into the search record: first hit, first empty, oldest frame
   always_comb begin
      scan_in_next = scan_in;
      if (scan_in.live && active) begin
         if (valid_ff && (page_ff == page) && !scan_in.hit_found) begin
            scan_in_next.hit_found = 1'b1;
            scan_in_next.hit_slot  = MY_SLOT;
            scan_in_next.hit_rank  = rank_wide;
         end
         if (!valid_ff && !scan_in.empty_found) begin
            scan_in_next.empty_found = 1'b1;
            scan_in_next.empty_slot  = MY_SLOT;
         end
         if (rank_wide > scan_in.victim_rank) begin
            scan_in_next.victim_slot = MY_SLOT;
            scan_in_next.victim_rank = rank_wide;
         end
      end
   end

   // Age valid active frames younger than the limit, up to the rank ceiling
   assign age = active && valid_ff && !is_target &&
                (!update.limit_en || (rank_wide < update.limit)) &&
                (rank_ff < RANK_CEIL);

   // Advance the search record and apply the broadcast update
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         scan_ff  <= lru_pkg::SCAN_IDLE;
      end else begin
         scan_ff <= scan_in_next;
         if (update.apply) begin
            if (is_target) begin
               rank_ff <= '0;
               if (update.write_page) begin
                  valid_ff <= 1'b1;
               end
            end else if (age) begin
               rank_ff <= rank_ff + RANK_W'(1);
            end
         end
      end
   end

   // Load the page on a fault into this frame
   always_ff @(posedge clock) begin
      if (update.apply && is_target && update.write_page) begin
         page_ff <= page;
      end
   end

endmodule

// ===== hw/rtl/lru_ctrl.sv =====
// Sequencer: takes requests, launches the search record, commits the update and totals.
module lru_ctrl #(
   parameter int FRAME_COUNT = 8,
   parameter int PAGE_W      = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   lru_req_if.sink                     req_chan,
   lru_rsp_if.source                   rsp_chan,
   input  logic                        csr_write_enable,
   input  logic [lru_pkg::CSR_W-1:0]   csr_write_data,
   output lru_pkg::scan_type           scan_head,
   input  lru_pkg::scan_type           scan_tail,
   output lru_pkg::update_type         update,
   output logic [PAGE_W-1:0]           page,
   output logic [lru_pkg::COUNT_W-1:0] active_count
);

   localparam logic [lru_pkg::COUNT_W-1:0] FRAME_MAX = lru_pkg::COUNT_W'(FRAME_COUNT);

   lru_pkg::state_type           state_ff;
   lru_pkg::state_type           state_in;
   logic                         launch_ff;
   logic                         launch_in;
   logic [lru_pkg::CSR_W-1:0]    csr_ff;
   logic [PAGE_W-1:0]            page_ff;
   lru_pkg::scan_type            result_ff;
   logic [lru_pkg::TOTAL_W-1:0]  hits_ff;
   logic [lru_pkg::TOTAL_W-1:0]  faults_ff;
   logic [lru_pkg::TOTAL_W-1:0]  hits_in;
   logic [lru_pkg::TOTAL_W-1:0]  faults_in;
   logic                         rsp_valid_ff;
   logic                         rsp_hit_ff;
   logic [lru_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [lru_pkg::TOTAL_W-1:0]  rsp_hits_ff;
   logic [lru_pkg::TOTAL_W-1:0]  rsp_faults_ff;
   logic [lru_pkg::IDX_W-1:0]    commit_slot;
   logic                         out_free;
   logic                         accept;
   logic                         commit;
   logic [lru_pkg::COUNT_W-1:0]  csr_wide;

   // Clamp the frame count into one .. FRAME_COUNT
   assign csr_wide = lru_pkg::COUNT_W'(csr_ff);
   always_comb begin
      if (csr_ff == '0) begin
         active_count = lru_pkg::COUNT_W'(1);
      end else if (csr_wide > FRAME_MAX) begin
         active_count = FRAME_MAX;
      end else begin
         active_count = csr_wide;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;
   assign page     = page_ff;

   // Start the search record at the head of the chain
   always_comb begin
      scan_head      = lru_pkg::SCAN_IDLE;
      scan_head.live = launch_ff;
   end

   // Pick the frame: hit, else first empty, else oldest
   always_comb begin
      if (result_ff.hit_found) begin
         commit_slot = result_ff.hit_slot;
      end else if (result_ff.empty_found) begin
         commit_slot = result_ff.empty_slot;
      end else begin
         commit_slot = result_ff.victim_slot;
      end
   end

   // Saturating totals after this request
   always_comb begin
      hits_in   = hits_ff;
      faults_in = faults_ff;
      if (result_ff.hit_found) begin
         if (hits_ff != '1) begin
            hits_in = hits_ff + lru_pkg::TOTAL_W'(1);
         end
      end else if (faults_ff != '1) begin
         faults_in = faults_ff + lru_pkg::TOTAL_W'(1);
      end
   end

   // Next state and update broadcast
   always_comb begin
      state_in          = state_ff;
      launch_in         = 1'b0;
      commit            = 1'b0;
      req_chan.ready    = 1'b0;
      update            = '0;
      update.target     = commit_slot;
      update.write_page = !result_ff.hit_found;
      update.limit_en   = result_ff.hit_found;
      update.limit      = result_ff.hit_rank;
      case (state_ff)
         lru_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               launch_in = 1'b1;
               state_in  = lru_pkg::ST_SCAN;
            end
         end
         lru_pkg::ST_SCAN: begin
            if (scan_tail.live) begin
               state_in = lru_pkg::ST_COMMIT;
            end
         end
         lru_pkg::ST_COMMIT: begin
            if (out_free) begin
               commit       = 1'b1;
               update.apply = 1'b1;
               state_in     = lru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lru_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lru_pkg::ST_IDLE;
         launch_ff    <= 1'b0;
         csr_ff       <= lru_pkg::CSR_RESET;
         hits_ff      <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= launch_in;
         if (csr_write_enable) begin
            csr_ff <= csr_write_data;
         end
         if (commit) begin
            hits_ff      <= hits_in;
            faults_ff    <= faults_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold request page, search result and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_chan.page_number[PAGE_W-1:0];
      end
      if ((state_ff == lru_pkg::ST_SCAN) && scan_tail.live) begin
         result_ff <= scan_tail;
      end
      if (commit) begin
         rsp_hit_ff    <= result_ff.hit_found;
         rsp_slot_ff   <= commit_slot[lru_pkg::SLOT_OUT_W-1:0];
         rsp_hits_ff   <= hits_in;
         rsp_faults_ff <= faults_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.frame_slot  = rsp_slot_ff;
   assign rsp_chan.hit_total   = rsp_hits_ff;
   assign rsp_chan.fault_total = rsp_faults_ff;

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// Fully associative LRU page replacement: a chain of frame cells driven by one sequencer.
// Each request goes through these steps from acceptance to response: the search record walks
// the chain of frame cells (one cell per cycle, each folding in its hit, empty and age check),
// the search result is captured, and the update is committed to all cells at once. A new request
// is accepted once the previous one has committed, while its response may still wait in the
// output register; a response still waiting holds back the commit of the next request.
// csr_write_data sets the number of active frames (0 acts as 1, above FRAME_COUNT acts as
// FRAME_COUNT); write it only idle.
module lru_page_replacement #(
   parameter int FRAME_COUNT = 8,
   parameter int PAGE_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   lru_req_if.sink                   req_chan,
   lru_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [lru_pkg::CSR_W-1:0] csr_write_data
);

   localparam int PAGE_W = (PAGE_BITS < lru_pkg::PAGE_NUMBER_W) ? PAGE_BITS
                                                                : lru_pkg::PAGE_NUMBER_W;

   lru_pkg::scan_type           chain [FRAME_COUNT+1];
   lru_pkg::update_type         update;
   logic [PAGE_W-1:0]           page;
   logic [lru_pkg::COUNT_W-1:0] active_count;

   lru_ctrl #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_W      (PAGE_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .scan_head        (chain[0]),
      .scan_tail        (chain[FRAME_COUNT]),
      .update           (update),
      .page             (page),
      .active_count     (active_count)
   );

   // Row of frame cells, search record passed left to right
   for (genvar k = 0; k < FRAME_COUNT; k++) begin : g_cell
      lru_cell #(
         .INDEX       (k),
         .FRAME_COUNT (FRAME_COUNT),
         .PAGE_W      (PAGE_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .scan_in      (chain[k]),
         .scan_out     (chain[k+1]),
         .update       (update),
         .page         (page),
         .active_count (active_count)
      );
   end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the LRU page replacement block: directed and random requests.
module tb_top;

   localparam int FRAMES         = 8;
   localparam int RANK_CEIL      = FRAMES - 1;
   localparam int CHAIN_LATENCY  = FRAMES + 2;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 150;

   typedef struct {
      logic                           hit;
      logic [lru_pkg::SLOT_OUT_W-1:0] frame_slot;
      logic [lru_pkg::TOTAL_W-1:0]    hit_total;
      logic [lru_pkg::TOTAL_W-1:0]    fault_total;
   } lookup_result_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_write_enable;
   logic [lru_pkg::CSR_W-1:0] csr_write_data;

   lru_req_if req_bus ();
   lru_rsp_if rsp_bus ();

   lru_page_replacement #(
      .FRAME_COUNT(FRAMES),
      .PAGE_BITS  (lru_pkg::PAGE_NUMBER_W)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_bus),
      .rsp_chan        (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // Shadow copy of the frame table and the frame count register
   logic [lru_pkg::PAGE_NUMBER_W-1:0] shadow_page [FRAMES];
   logic                              shadow_valid[FRAMES];
   logic [2:0]                        shadow_rank [FRAMES];
   logic [lru_pkg::TOTAL_W-1:0]       shadow_hits;
   logic [lru_pkg::TOTAL_W-1:0]       shadow_faults;
   logic [lru_pkg::CSR_W-1:0]         shadow_frames_cfg;

   lookup_result_type pending_lookups[$];
   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   int  response_count = 0;
   bit  sender_eager   = 1'b0;
   bit  receiver_eager = 1'b0;

   // Page pools for the random phases
   logic [lru_pkg::PAGE_NUMBER_W-1:0] pool_base;
   logic [lru_pkg::PAGE_NUMBER_W-1:0] prior_base;
   int                                pool_span;

   always #10 clock = ~clock;

   // Watchdog: end the run after too long without any handshake
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int active_frames(input logic [lru_pkg::CSR_W-1:0] cfg);
      if (cfg == '0)
         return 1;
      if (cfg > FRAMES)
         return FRAMES;
      return int'(cfg);
   endfunction

   // Age the other valid active frames below the limit, then make the target most recent
   function automatic void age_frames(input int target, input int limit, input int act);
      for (int k = 0; k < act; k++) begin
         if (k != target && shadow_valid[k] && int'(shadow_rank[k]) < limit &&
             int'(shadow_rank[k]) < RANK_CEIL)
            shadow_rank[k] = shadow_rank[k] + 3'd1;
      end
      shadow_rank[target] = '0;
   endfunction

   // Look up one page in the shadow table, update it and return the expected response
   function automatic lookup_result_type lookup_page(
         input logic [lru_pkg::PAGE_NUMBER_W-1:0] page);
      lookup_result_type res;
      int act;
      int slot;
      bit found;
      bit empty_found;
      act = active_frames(shadow_frames_cfg);
      slot = 0;
      found = 1'b0;
      empty_found = 1'b0;
      for (int k = 0; k < act; k++) begin
         if (!found && shadow_valid[k] && shadow_page[k] == page) begin
            slot = k;
            found = 1'b1;
         end
      end
      if (found) begin
         age_frames(slot, int'(shadow_rank[slot]), act);
         if (shadow_hits != '1)
            shadow_hits = shadow_hits + 1;
      end else begin
         for (int k = 0; k < act; k++) begin
            if (!empty_found && !shadow_valid[k]) begin
               slot = k;
               empty_found = 1'b1;
            end
         end
         // No empty frame: evict the oldest, lowest index on a tie
         if (!empty_found) begin
            slot = 0;
            for (int k = 1; k < act; k++)
               if (shadow_rank[k] > shadow_rank[slot])
                  slot = k;
         end
         shadow_page[slot] = page;
         shadow_valid[slot] = 1'b1;
         age_frames(slot, FRAMES, act);
         if (shadow_faults != '1)
            shadow_faults = shadow_faults + 1;
      end
      res.hit = found;
      res.frame_slot = slot[lru_pkg::SLOT_OUT_W-1:0];
      res.hit_total = shadow_hits;
      res.fault_total = shadow_faults;
      return res;
   endfunction

   // Present one request after a random gap and record its expected response
   task automatic send_page(input logic [lru_pkg::PAGE_NUMBER_W-1:0] page);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 19);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.page_number <= page;
      do @(posedge clock); while (!req_bus.ready);
      pending_lookups.push_back(lookup_page(page));
   endtask

   // Drop the request and hold until every expected response has come
   task automatic drain_responses();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_lookups.size() != 0)
         @(posedge clock);
   endtask

   // Write the frame count once the block is idle
   task automatic write_frame_count(input logic [lru_pkg::CSR_W-1:0] value);
      drain_responses();
      repeat (CHAIN_LATENCY) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_frames_cfg = value;
   endtask

   // Mostly pages from a small pool so hits and evictions both occur
   function automatic logic [lru_pkg::PAGE_NUMBER_W-1:0] draw_page();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         return pool_base + lru_pkg::PAGE_NUMBER_W'($urandom_range(0, pool_span));
      if (pick < 80)
         return prior_base + lru_pkg::PAGE_NUMBER_W'($urandom_range(0, pool_span));
      return lru_pkg::PAGE_NUMBER_W'($urandom_range(0, 65535));
   endfunction

   // Fill all eight frames, hit, then evict the least recently used frame
   task automatic test_fill_and_evict();
      send_page(16'h0000);
      send_page(16'hFFFF);
      for (int p = 1; p <= 6; p++)
         send_page(lru_pkg::PAGE_NUMBER_W'(p));
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0007);
      send_page(16'h0000);
   endtask

   // Shrink to three frames, act as one at zero, then grow past the frame count
   task automatic test_frame_count_limits();
      write_frame_count(4'd3);
      send_page(16'h0100);
      send_page(16'h0002);
      send_page(16'h0101);
      write_frame_count(4'd0);
      send_page(16'h0101);
      send_page(16'h5555);
      write_frame_count(4'd15);
      send_page(16'h0004);
      send_page(16'h0006);
      send_page(16'hAAAA);
   endtask

   // Random phases over a range of frame counts, one pause for a full drain
   task automatic test_random_mix();
      logic [lru_pkg::CSR_W-1:0] counts[12];
      counts = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd4, 4'd2, 4'd7, 4'd3, 4'd5, 4'd6, 4'd9, 4'd8};
      pool_base = lru_pkg::PAGE_NUMBER_W'($urandom_range(0, 65535));
      foreach (counts[i]) begin
         write_frame_count(counts[i]);
         prior_base = pool_base;
         pool_base = lru_pkg::PAGE_NUMBER_W'($urandom_range(0, 65535));
         pool_span = active_frames(counts[i]) + $urandom_range(0, 3);
         sender_eager = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (i == 5 && n == PHASE_ITEMS / 2)
               drain_responses();
            send_page(draw_page());
         end
      end
   endtask

   // Compare each response with the oldest expectation
   initial begin : check_responses
      int stall;
      lookup_result_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = receiver_eager ? 0 : $urandom_range(0, 19);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (pending_lookups.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_bus.hit !== want.hit) begin
               $error("hit: expected %0d, actual %0d", want.hit, rsp_bus.hit);
               mismatch_count++;
            end
            if (rsp_bus.frame_slot !== want.frame_slot) begin
               $error("frame_slot: expected %0d, actual %0d", want.frame_slot,
                      rsp_bus.frame_slot);
               mismatch_count++;
            end
            if (rsp_bus.hit_total !== want.hit_total) begin
               $error("hit_total: expected %0d, actual %0d", want.hit_total,
                      rsp_bus.hit_total);
               mismatch_count++;
            end
            if (rsp_bus.fault_total !== want.fault_total) begin
               $error("fault_total: expected %0d, actual %0d", want.fault_total,
                      rsp_bus.fault_total);
               mismatch_count++;
            end
         end
         response_count++;
         if (response_count % 64 == 0)
            receiver_eager = ($urandom_range(0, 2) == 0);
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.page_number = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      // Clear the shadow table to its reset state
      for (int k = 0; k < FRAMES; k++) begin
         shadow_page[k] = '0;
         shadow_valid[k] = 1'b0;
         shadow_rank[k] = '0;
      end
      shadow_hits = '0;
      shadow_faults = '0;
      shadow_frames_cfg = lru_pkg::CSR_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fill_and_evict();
      test_frame_count_limits();
      test_random_mix();

      drain_responses();
      repeat (CHAIN_LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== lru_page_replacement.f =====
hw/rtl/lru_pkg.sv
hw/rtl/lru_req_if.sv
hw/rtl/lru_rsp_if.sv
hw/rtl/lru_cell.sv
hw/rtl/lru_ctrl.sv
hw/rtl/lru_page_replacement.sv
bench/tb_top.sv
